// ===== rtl/otm_pkg.sv =====
package otm_pkg;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned BITS_W     = 4;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned BIN_IDX_W  = 6;

  localparam logic [CNT_W-1:0]  MAX_RESULTS = 6'd63;
  localparam logic [BITS_W-1:0] BYTE_BITS   = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER_MASK = 2'd0,
    REG_HEADER_BITS  = 2'd1,
    REG_BODY_BITS    = 2'd2,
    REG_HEADER_BYTES = 2'd3
  } otm_reg_e;

  typedef enum logic [2:0] {
    ST_SCAN,
    ST_IDLE,
    ST_RES,
    ST_DATA,
    ST_PAD
  } otm_state_e;

  typedef struct packed {
    logic [BIN_IDX_W-1:0] bin_index;
    logic [BYTE_W-1:0]    symbol_value;
    logic                 pad;
    logic                 in_header;
    logic                 packet_start;
    logic                 symbol_end;
    logic                 last;
  } otm_result_t;

  typedef struct packed {
    logic scan_start;
    logic scan_step;
    logic load;
    logic emit_res;
    logic emit_data;
    logic data_end;
    logic emit_pad;
    logic finish;
  } otm_cmd_t;

  typedef struct packed {
    logic stale;
    logic scan_last;
    logic res_pending;
    logic data_more;
    logic pad_needed;
    logic pad_more;
    logic out_free;
  } otm_status_t;

  function automatic logic [BITS_W-1:0] clamp_bits(logic [BITS_W-1:0] v);
    logic [BITS_W-1:0] r;
    r = v;
    if (v == '0) r = 4'd1;
    else if (v > BYTE_BITS) r = BYTE_BITS;
    return r;
  endfunction

  // k in 0..8
  function automatic logic [BYTE_W-1:0] low_mask(logic [BITS_W-1:0] k);
    return 8'hFF >> (BYTE_BITS - k);
  endfunction

endpackage

// ===== rtl/otm_intf.sv =====
interface otm_in_if import otm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              packet_end;

  modport source (output valid, data_byte, packet_end, input ready);
  modport sink (input valid, data_byte, packet_end, output ready);
endinterface

interface otm_out_if import otm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [BIN_IDX_W-1:0] bin_index;
  logic [BYTE_W-1:0]    symbol_value;
  logic                 pad;
  logic                 in_header;
  logic                 packet_start;
  logic                 symbol_end;
  logic                 last;

  modport source (output valid, bin_index, symbol_value, pad, in_header, packet_start,
                  symbol_end, last, input ready);
  modport sink (input valid, bin_index, symbol_value, pad, in_header, packet_start,
                symbol_end, last, output ready);
endinterface

// ===== rtl/otm_ctrl.sv =====
module otm_ctrl import otm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  otm_status_t status_i,
  output otm_cmd_t    cmd_o
);

  otm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (status_i.stale) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            cmd_o.load = 1'b1;
            state_d    = status_i.res_pending ? ST_RES : ST_DATA;
          end
        end
      end
      ST_RES: begin
        if (status_i.out_free) begin
          cmd_o.emit_res = 1'b1;
          state_d        = ST_DATA;
        end
      end
      ST_DATA: begin
        if (status_i.out_free) begin
          if (status_i.data_more) begin
            cmd_o.emit_data = 1'b1;
          end else begin
            cmd_o.data_end = 1'b1;
            if (status_i.pad_needed) begin
              state_d = ST_PAD;
            end else begin
              cmd_o.finish = 1'b1;
              state_d      = ST_IDLE;
            end
          end
        end
      end
      ST_PAD: begin
        if (status_i.out_free) begin
          if (status_i.pad_more) begin
            cmd_o.emit_pad = 1'b1;
          end else begin
            cmd_o.finish = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/otm_datapath.sv =====
module otm_datapath import otm_pkg::*; #(
  parameter int unsigned FFT_BINS          = 64,
  parameter int unsigned MAX_USED_CARRIERS = 56
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [BYTE_W-1:0]     data_byte_i,
  input  logic                  packet_end_i,
  input  logic                  out_ready_i,
  output logic                  out_valid_o,
  output otm_result_t           out_item_o,
  input  otm_cmd_t              cmd_i,
  output otm_status_t           status_o
);

  localparam int unsigned BIN_W = $clog2(FFT_BINS);

  // configuration
  logic [FFT_BINS-1:0] mask_q, mask_d;
  logic [BITS_W-1:0]   hbits_q, hbits_d, bbits_q, bbits_d;
  logic [BYTE_W-1:0]   hbytes_q, hbytes_d;

  // carrier table scan
  logic              stale_q, stale_d;
  logic [BIN_W-1:0]  sb_q, sb_d;
  logic [SLOT_W-1:0] cnt_q, cnt_d;
  logic [SLOT_W-1:0] used_q, used_d;
  logic [BIN_W-1:0]  first_bin_q, first_bin_d;

  // mapper state
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [BIN_W-1:0]  bin_q, bin_d;
  logic [BYTE_W-1:0] res_bits_q, res_bits_d;
  logic [BITS_W-1:0] res_miss_q, res_miss_d;
  logic [BYTE_W-1:0] hcount_q, hcount_d;
  logic              map_hdr_q, map_hdr_d;
  logic              first_sym_q, first_sym_d;

  // current item
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              pkt_end_q, pkt_end_d;
  logic [BITS_W-1:0] nb_q, nb_d;
  logic [BITS_W-1:0] off_q, off_d;
  logic [CNT_W-1:0]  n_q, n_d;

  // result staging and output register
  otm_result_t pend_q, pend_d, out_q, out_d;
  logic        pend_v_q, pend_v_d, out_v_q, out_v_d;

  logic              ending, can_put, is_end, do_put, out_free;
  logic              scan_hit;
  logic [SLOT_W-1:0] cnt_nx;
  logic [BIN_W-1:0]  first_nx, bin_nx;
  logic [BITS_W-1:0] m, held, rem;
  logic [4:0]        off_sum;
  logic [BYTE_W-1:0] res_val, data_val, put_val;
  otm_result_t       new_res, last_res;

  assign ending   = map_hdr_q ? ((9'(hcount_q) + 9'd1) >= 9'(hbytes_q)) : pkt_end_q;
  assign can_put  = (used_q != '0) && (n_q != MAX_RESULTS);
  assign is_end   = (slot_q + 6'd1) == used_q;
  assign do_put   = (cmd_i.emit_res || cmd_i.emit_data || cmd_i.emit_pad) && can_put;
  assign out_free = !out_v_q || out_ready_i;

  assign scan_hit = mask_q[sb_q] && (cnt_q != SLOT_W'(MAX_USED_CARRIERS));
  assign cnt_nx   = cnt_q + SLOT_W'(scan_hit);
  assign first_nx = (scan_hit && (cnt_q == '0)) ? sb_q : first_bin_q;

  assign m        = (res_miss_q >= nb_q) ? nb_q : res_miss_q;
  assign held     = nb_q - m;
  assign res_val  = (res_bits_q & low_mask(held)) | ((byte_q & low_mask(m)) << held);
  assign off_sum  = 5'(off_q) + 5'(nb_q);
  assign data_val = (byte_q >> off_q) & low_mask(nb_q);
  assign rem      = BYTE_BITS - off_q;
  assign put_val  = cmd_i.emit_res ? res_val : (cmd_i.emit_data ? data_val : '0);

  always_comb begin
    bin_nx = first_bin_q;
    for (int i = FFT_BINS - 1; i >= 0; i--) begin
      if (mask_q[i] && (BIN_W'(i) > bin_q)) bin_nx = BIN_W'(i);
    end
  end

  always_comb begin
    new_res              = '0;
    new_res.bin_index    = BIN_IDX_W'(bin_q);
    new_res.symbol_value = put_val;
    new_res.pad          = cmd_i.emit_pad;
    new_res.in_header    = map_hdr_q;
    new_res.packet_start = first_sym_q;
    new_res.symbol_end   = is_end;
    new_res.last         = 1'b0;
    last_res             = pend_q;
    last_res.last        = 1'b1;
  end

  assign status_o.stale       = stale_q;
  assign status_o.scan_last   = sb_q == BIN_W'(FFT_BINS - 1);
  assign status_o.res_pending = res_miss_q != '0;
  assign status_o.data_more   = off_sum <= 5'd8;
  assign status_o.pad_needed  = ending && (used_q != '0) && (slot_q != '0);
  assign status_o.pad_more    = (slot_q != '0) && can_put;
  assign status_o.out_free    = out_free;

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

  always_comb begin
    mask_d      = mask_q;
    hbits_d     = hbits_q;
    bbits_d     = bbits_q;
    hbytes_d    = hbytes_q;
    stale_d     = stale_q;
    sb_d        = sb_q;
    cnt_d       = cnt_q;
    used_d      = used_q;
    first_bin_d = first_bin_q;
    slot_d      = slot_q;
    bin_d       = bin_q;
    res_bits_d  = res_bits_q;
    res_miss_d  = res_miss_q;
    hcount_d    = hcount_q;
    map_hdr_d   = map_hdr_q;
    first_sym_d = first_sym_q;
    byte_d      = byte_q;
    pkt_end_d   = pkt_end_q;
    nb_d        = nb_q;
    off_d       = off_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pend_v_d    = pend_v_q;
    out_d       = out_q;
    out_v_d     = out_v_q;

    if (cmd_i.scan_start) begin
      stale_d = 1'b0;
      sb_d    = '0;
      cnt_d   = '0;
    end
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CARRIER_MASK: begin
          mask_d  = cfg_data_i[FFT_BINS-1:0];
          stale_d = 1'b1;
        end
        REG_HEADER_BITS:  hbits_d  = cfg_data_i[BITS_W-1:0];
        REG_BODY_BITS:    bbits_d  = cfg_data_i[BITS_W-1:0];
        REG_HEADER_BYTES: hbytes_d = cfg_data_i[BYTE_W-1:0];
        default: ;
      endcase
    end

    if (cmd_i.scan_step) begin
      sb_d  = BIN_W'(sb_q + 1'b1);
      cnt_d = cnt_nx;
      first_bin_d = first_nx;
      if (scan_hit && (cnt_q == slot_q)) bin_d = sb_q;
      if (status_o.scan_last) begin
        used_d = cnt_nx;
        if ((cnt_nx != '0) && (slot_q >= cnt_nx)) begin
          slot_d = '0;
          bin_d  = first_nx;
        end
      end
    end

    if (cmd_i.load) begin
      byte_d    = data_byte_i;
      pkt_end_d = packet_end_i;
      nb_d      = clamp_bits(map_hdr_q ? hbits_q : bbits_q);
      off_d     = '0;
      n_d       = '0;
    end

    if (cmd_i.emit_res) begin
      off_d      = m;
      res_miss_d = '0;
      res_bits_d = '0;
    end
    if (cmd_i.emit_data) off_d = off_sum[BITS_W-1:0];

    if (cmd_i.data_end) begin
      if (ending) begin
        res_bits_d = '0;
        res_miss_d = '0;
      end else if (off_q < BYTE_BITS) begin
        res_bits_d = (byte_q >> off_q) & low_mask(rem);
        res_miss_d = nb_q - rem;
      end
    end

    if (out_v_q && out_ready_i) out_v_d = 1'b0;

    if (do_put) begin
      n_d = n_q + 1'b1;
      if (is_end) begin
        slot_d      = '0;
        bin_d       = first_bin_q;
        first_sym_d = 1'b0;
      end else begin
        slot_d = slot_q + 1'b1;
        bin_d  = bin_nx;
      end
      if (pend_v_q) begin
        out_d   = pend_q;
        out_v_d = 1'b1;
      end
      pend_d   = new_res;
      pend_v_d = 1'b1;
    end

    if (cmd_i.finish) begin
      if (pend_v_q) begin
        out_d    = last_res;
        out_v_d  = 1'b1;
        pend_v_d = 1'b0;
      end
      if (map_hdr_q) begin
        hcount_d = ending ? '0 : hcount_q + 1'b1;
      end else if (ending) begin
        hcount_d = '0;
      end
      if (ending) begin
        map_hdr_d = !map_hdr_q;
        if (!map_hdr_q) first_sym_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '1;
      hbits_q     <= 4'd1;
      bbits_q     <= 4'd2;
      hbytes_q    <= 8'd24;
      stale_q     <= 1'b1;
      sb_q        <= '0;
      cnt_q       <= '0;
      used_q      <= '0;
      first_bin_q <= '0;
      slot_q      <= '0;
      bin_q       <= '0;
      res_bits_q  <= '0;
      res_miss_q  <= '0;
      hcount_q    <= '0;
      map_hdr_q   <= 1'b1;
      first_sym_q <= 1'b1;
      n_q         <= '0;
      pend_v_q    <= 1'b0;
      out_v_q     <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      hbits_q     <= hbits_d;
      bbits_q     <= bbits_d;
      hbytes_q    <= hbytes_d;
      stale_q     <= stale_d;
      sb_q        <= sb_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      first_bin_q <= first_bin_d;
      slot_q      <= slot_d;
      bin_q       <= bin_d;
      res_bits_q  <= res_bits_d;
      res_miss_q  <= res_miss_d;
      hcount_q    <= hcount_d;
      map_hdr_q   <= map_hdr_d;
      first_sym_q <= first_sym_d;
      n_q         <= n_d;
      pend_v_q    <= pend_v_d;
      out_v_q     <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q    <= byte_d;
    pkt_end_q <= pkt_end_d;
    nb_q      <= nb_d;
    off_q     <= off_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

endmodule

// ===== rtl/ofdm_tone_map_bit_mapper_top.sv =====
// OFDM subcarrier bit mapper.
// Input channel in_i: one packet byte per item, packet_end on the last byte.
// Output channel out_o: one carrier per item (bin, constellation index, flags);
// last marks the final carrier caused by an input byte. Bytes are cut from the
// low bit up into header_bits or body_bits wide indices.
// Config port: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 mask,
// 1 header bits, 2 body bits, 3 header bytes). The user must write only while
// the block is idle; the block itself does not enforce this. An accepted byte
// yields one carrier per cycle from the shared bit slicer while the output is
// free: after the accept, a held residual group is sent first, then one index
// per step, an end step, and, when padding, one pad carrier per step and a
// closing step. A carrier waits in the staging register until the next one
// or the end of the byte moves it to the output register. One byte is worked
// on at a time. After reset and after every carrier_mask write the bin table
// is rebuilt by walking the mask one bin per cycle, with ready low.
// When the receiver stalls, the output register and one staging register fill
// and the slicer waits; a new byte is taken while the last carrier still
// waits in the output register.
module ofdm_tone_map_bit_mapper_top import otm_pkg::*; #(
  parameter int unsigned FFT_BINS          = 64,
  parameter int unsigned MAX_USED_CARRIERS = 56
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  otm_in_if.sink                in_i,
  otm_out_if.source             out_o
);

  otm_cmd_t    cmd;
  otm_status_t status;
  otm_result_t out_item;
  logic        out_valid;

  otm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  otm_datapath #(
    .FFT_BINS          (FFT_BINS),
    .MAX_USED_CARRIERS (MAX_USED_CARRIERS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .data_byte_i  (in_i.data_byte),
    .packet_end_i (in_i.packet_end),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_valid),
    .out_item_o   (out_item),
    .cmd_i        (cmd),
    .status_o     (status)
  );

  assign out_o.valid        = out_valid;
  assign out_o.bin_index    = out_item.bin_index;
  assign out_o.symbol_value = out_item.symbol_value;
  assign out_o.pad          = out_item.pad;
  assign out_o.in_header    = out_item.in_header;
  assign out_o.packet_start = out_item.packet_start;
  assign out_o.symbol_end   = out_item.symbol_end;
  assign out_o.last         = out_item.last;

endmodule

// ===== rtl/otm_checker.sv =====
module otm_checker import otm_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [BIN_IDX_W-1:0] out_bin_index_i,
  input logic [BYTE_W-1:0] out_symbol_value_i,
  input logic              out_pad_i,
  input logic              out_symbol_end_i,
  input logic              out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_bin_index_i) &&
    $stable(out_symbol_value_i) && $stable(out_last_i))
    else $error("output item changed while stalled");

  a_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready high right after a byte was taken");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_pad_i |-> out_symbol_value_i == '0)
    else $error("pad carrier with nonzero value");

  a_pad_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_pad_i && out_symbol_end_i |-> out_last_i)
    else $error("pad closing a symbol is not the last carrier of its byte");

endmodule

bind ofdm_tone_map_bit_mapper_top otm_checker u_otm_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_bin_index_i    (out_o.bin_index),
  .out_symbol_value_i (out_o.symbol_value),
  .out_pad_i          (out_o.pad),
  .out_symbol_end_i   (out_o.symbol_end),
  .out_last_i         (out_o.last)
);
